### design/dotted_ipv4_address_parser_defines.svh
// Assertion macros used by the dotted IPv4 parser back end
`ifndef DOTTED_IPV4_ADDRESS_PARSER_DEFINES_SVH
`define DOTTED_IPV4_ADDRESS_PARSER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define DIP_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define DIP_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### design/dip_pkg.sv
// Types and constants for the dotted IPv4 address parser
package dip_pkg;

  // default depth of the token queue between classifier and parser
  localparam int DIP_QUEUE_DEPTH = 2;

  // largest value the last part may hold after 1, 2 or 3 dotted parts
  localparam logic [31:0] LAST_MAX_1 = 32'h00ff_ffff;
  localparam logic [31:0] LAST_MAX_2 = 32'h0000_ffff;
  localparam logic [31:0] LAST_MAX_3 = 32'h0000_00ff;

  // byte classes produced by the front end
  typedef enum logic [2:0] {
    CLS_END,     // zero byte, terminates the string
    CLS_DIGIT,   // 0-9
    CLS_HEXLET,  // a-f / A-F
    CLS_X,       // x / X
    CLS_DOT,
    CLS_WS,      // space, tab, LF, VT, FF, CR
    CLS_OTHER
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] val;  // digit value for digits and hex letters
  } tok_t;

  typedef enum logic [2:0] {
    PH_START,  // expect first digit of a part
    PH_ZERO,   // leading zero seen
    PH_NUM,    // inside the digits of a part
    PH_TRAIL,  // trailing whitespace seen
    PH_FAIL
  } phase_t;

  typedef enum logic [1:0] {
    RAD_DEC,
    RAD_OCT,
    RAD_HEX
  } radix_t;

  // datapath actions chosen by the parser FSM
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,    // first digit of a part
    ACT_DIGIT,   // accumulate a digit
    ACT_DOT,     // close a part
    ACT_FINISH,  // terminator after a well-formed string
    ACT_REJECT   // terminator after a bad string
  } act_t;

endpackage

### design/dotted_ipv4_address_parser.sv
// Top level of the streaming dotted IPv4 address parser
//
// Input channel (in_valid/in_ready, ch): one byte of address text per
// transfer; a zero byte ends the string. Output channel (out_valid/
// out_ready, ok, address): one result per string, on its zero byte.
// ok is 1 when the text parsed as an address; address is 0 otherwise.
// Throughput: one byte per cycle, unless a terminator waits for room in
// the result register; each digit is accumulated by a shift-and-add.
// The zero byte is written into the token queue; the parser pops it and
// its result is registered in the output register, raising out_valid.
// A classifier turns bytes into tokens pushed into a QUEUE_DEPTH-entry
// queue; the parser pops them. If the receiver stalls, a finished result
// waits in the output register, the parser keeps consuming bytes until
// it reaches the next terminator, and the queue then fills and drops
// in_ready.
// Reset (rst, synchronous) empties the queue, clears out_valid and
// returns the parser to the start of an address string.
module dotted_ipv4_address_parser import dip_pkg::*; #(
  parameter int QUEUE_DEPTH = DIP_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [31:0] address
);

  logic q_full;
  logic q_nonempty;
  logic push;
  logic pop;
  tok_t push_tok;
  tok_t q_head;

  dip_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ch       (ch),
    .q_full   (q_full),
    .push     (push),
    .push_tok (push_tok)
  );

  dip_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  dip_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .address    (address)
  );

endmodule

### design/dip_front.sv
// Front end: accepts text bytes and classifies them into tokens
module dip_front import dip_pkg::*; (
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       q_full,
  output logic       push,
  output tok_t       push_tok
);

  // accept whenever the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // byte classification
  always_comb begin
    push_tok.val = ch[3:0];
    if (ch == 8'h00) begin
      push_tok.cls = CLS_END;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      push_tok.cls = CLS_DIGIT;
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      push_tok.cls = CLS_HEXLET;
      push_tok.val = ch[3:0] + 4'd9;  // 'a'/'A' low nibble 1 -> 10
    end else if (ch == 8'h78 || ch == 8'h58) begin
      push_tok.cls = CLS_X;
    end else if (ch == 8'h2e) begin
      push_tok.cls = CLS_DOT;
    end else if (ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0d)) begin
      push_tok.cls = CLS_WS;
    end else begin
      push_tok.cls = CLS_OTHER;
    end
  end

endmodule

### design/dip_queue.sv
// Small token queue between the classifier and the parser
module dip_queue import dip_pkg::*; #(
  parameter int DEPTH = DIP_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tok_t push_tok,
  input  logic pop,
  output logic full,
  output logic nonempty,
  output tok_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  tok_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == FULL_CNT);
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### design/dip_back.sv
// Back end: parser state machine, accumulator and result register
module dip_back import dip_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_nonempty,
  input  tok_t        q_head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [31:0] address
);

`include "dotted_ipv4_address_parser_defines.svh"

  phase_t      phase, phase_next;
  radix_t      radix, radix_next;
  act_t        act;
  logic [31:0] accum, accum_next;
  logic [1:0]  part_count, part_count_next;
  logic [7:0]  first_part, first_part_next;
  logic [15:0] second_part, second_part_next;
  logic [23:0] third_part, third_part_next;

  radix_t      radix_eff;
  logic        emit_en;
  logic        emit_ok;
  logic [31:0] emit_addr;
  logic [31:0] scaled;
  logic [31:0] merged;
  logic        too_big;

  // a terminator needs room in the result register; other tokens never wait
  assign pop = q_nonempty &&
               (q_head.cls != CLS_END || !out_valid || out_ready);

  // after a leading zero, anything but x/X continues as octal
  assign radix_eff = (phase == PH_ZERO) ? RAD_OCT : radix;

  // next state and action
  always_comb begin
    phase_next = phase;
    radix_next = radix;
    act        = ACT_NONE;
    if (pop) begin
      unique case (phase)
        PH_START: begin
          if (q_head.cls == CLS_END) begin
            act = ACT_REJECT;
          end else if (q_head.cls == CLS_DIGIT) begin
            act = ACT_LOAD;
            if (q_head.val == 4'd0) begin
              phase_next = PH_ZERO;
            end else begin
              radix_next = RAD_DEC;
              phase_next = PH_NUM;
            end
          end else begin
            phase_next = PH_FAIL;
          end
        end
        PH_ZERO, PH_NUM: begin
          if (phase == PH_ZERO && q_head.cls == CLS_X) begin
            radix_next = RAD_HEX;
            phase_next = PH_NUM;
          end else begin
            radix_next = radix_eff;
            phase_next = PH_NUM;
            case (q_head.cls)
              CLS_DIGIT: act = ACT_DIGIT;
              CLS_HEXLET: begin
                if (radix_eff == RAD_HEX) begin
                  act = ACT_DIGIT;
                end else begin
                  phase_next = PH_FAIL;
                end
              end
              CLS_DOT: begin
                if (part_count == 2'd3) begin
                  phase_next = PH_FAIL;
                end else begin
                  act        = ACT_DOT;
                  radix_next = RAD_DEC;
                  phase_next = PH_START;
                end
              end
              CLS_END: act = ACT_FINISH;
              CLS_WS:  phase_next = PH_TRAIL;
              default: phase_next = PH_FAIL;
            endcase
          end
        end
        PH_TRAIL: begin
          if (q_head.cls == CLS_END) begin
            act = ACT_FINISH;
          end
        end
        default: begin
          if (q_head.cls == CLS_END) begin
            act = ACT_REJECT;
          end
        end
      endcase
      // any result returns the parser to its reset state
      if (act == ACT_FINISH || act == ACT_REJECT) begin
        phase_next = PH_START;
        radix_next = RAD_DEC;
      end
    end
  end

  // accumulator scaling: x16, x8 or x10 as shifts and one add
  always_comb begin
    case (radix_eff)
      RAD_HEX: scaled = {accum[27:0], 4'b0};
      RAD_OCT: scaled = {accum[28:0], 3'b0};
      default: scaled = {accum[28:0], 3'b0} + {accum[30:0], 1'b0};
    endcase
  end

  // range check of the last part and merge with the stored parts
  always_comb begin
    case (part_count)
      2'd1: begin
        too_big = (accum > LAST_MAX_1);
        merged  = accum | {first_part, 24'b0};
      end
      2'd2: begin
        too_big = (accum > LAST_MAX_2);
        merged  = accum | {first_part, 24'b0} | {second_part, 16'b0};
      end
      2'd3: begin
        too_big = (accum > LAST_MAX_3);
        merged  = accum | {first_part, 24'b0} | {second_part, 16'b0}
                | {third_part, 8'b0};
      end
      default: begin
        too_big = 1'b0;
        merged  = accum;
      end
    endcase
  end

  // datapath next values and result
  always_comb begin
    accum_next       = accum;
    part_count_next  = part_count;
    first_part_next  = first_part;
    second_part_next = second_part;
    third_part_next  = third_part;
    emit_en          = 1'b0;
    emit_ok          = 1'b0;
    emit_addr        = '0;
    unique case (act)
      ACT_LOAD:  accum_next = {28'b0, q_head.val};
      ACT_DIGIT: accum_next = scaled + {28'b0, q_head.val};
      ACT_DOT: begin
        case (part_count)
          2'd0:    first_part_next  = accum[7:0];
          2'd1:    second_part_next = accum[15:0];
          default: third_part_next  = accum[23:0];
        endcase
        part_count_next = part_count + 2'd1;
        accum_next      = '0;
      end
      ACT_FINISH, ACT_REJECT: begin
        emit_en          = 1'b1;
        emit_ok          = (act == ACT_FINISH) && !too_big;
        emit_addr        = emit_ok ? merged : '0;
        accum_next       = '0;
        part_count_next  = '0;
        first_part_next  = '0;
        second_part_next = '0;
        third_part_next  = '0;
      end
      default: ;
    endcase
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      radix       <= RAD_DEC;
      accum       <= '0;
      part_count  <= '0;
      first_part  <= '0;
      second_part <= '0;
      third_part  <= '0;
    end else begin
      phase       <= phase_next;
      radix       <= radix_next;
      accum       <= accum_next;
      part_count  <= part_count_next;
      first_part  <= first_part_next;
      second_part <= second_part_next;
      third_part  <= third_part_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      ok      <= emit_ok;
      address <= emit_addr;
    end
  end

  `DIP_ASSERT_NOW(a_no_overwrite, emit_en, !out_valid || out_ready, "result overwritten")
  `DIP_ASSERT_NEXT(a_clear_after_emit, emit_en, phase == PH_START && part_count == 2'd0 && accum == 32'd0, "state not cleared after result")
  `DIP_ASSERT_NOW(a_fail_addr_zero, out_valid && !ok, address == 32'd0, "address nonzero on failure")
  `DIP_ASSERT_NOW(a_emit_only_on_end, emit_en, pop && q_head.cls == CLS_END, "result without terminator")

endmodule
